@@ design/gbd_pkg.sv @@
// Package for the guided bilateral denoiser: field widths, action codes,
// register indexes and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package gbd_pkg;

  // Internal coordinate width; covers the largest frame size and the 10-bit size registers.
  localparam int COORD_W = 13;

  localparam int ACTION_W = 2;
  localparam int XY_W     = 9;
  localparam int CH_W     = 8;
  localparam int WIDX_W   = 7;
  localparam int WVAL_W   = 17;
  localparam int PIX_W    = 7 * CH_W;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Action codes carried in in_tuser.
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WEIGHT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FILTER = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NTHR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DTHR   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // input transfer this cycle
    logic capture;      // latch a filter item and its window bounds
    logic rd_centre;    // read the centre pixel
    logic latch_centre; // keep the centre pixel's guide data
    logic scan_issue;   // read the next window pixel
    logic div_init;     // load the dividers
    logic div_step;     // one quotient bit per channel
    logic load_out;     // move the result into the output register
  } gbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;      // clipped window holds no pixel
    logic outside;    // coordinate beyond the frame stores
    logic scan_last;  // current read is the last of the window
    logic pipe_busy;  // accumulation pipeline still holds reads
    logic out_busy;   // output register holds an untaken result
  } gbd_sts_t;

endpackage
`default_nettype wire

@@ design/gbd_datapath.sv @@
// Datapath of the guided bilateral denoiser: configuration registers, frame and
// weight memories, window scan, weighted accumulation, dividers, output register.
// Depends on gbd_pkg.
`default_nettype none
module gbd_datapath import gbd_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [ACTION_W-1:0]   in_action,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire gbd_cmd_t              cmd,
  output gbd_sts_t                   sts
);

  localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int WENT   = 2 * MAX_RADIUS * MAX_RADIUS + 1;
  localparam int WIW    = $clog2(WENT);
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int NWIN   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int SW_W   = WVAL_W + $clog2(NWIN);
  localparam int S_W    = SW_W + CH_W;
  localparam int P_W    = WVAL_W + CH_W;

  // Input fields.
  logic [XY_W-1:0]   f_x, f_y;
  logic [PIX_W-1:0]  f_pix;
  logic [WIDX_W-1:0] f_widx;
  logic [WVAL_W-1:0] f_wval;
  assign f_x    = in_data[8:0];
  assign f_y    = in_data[17:9];
  assign f_pix  = in_data[73:18];
  assign f_widx = in_data[80:74];
  assign f_wval = in_data[97:81];

  // Configuration registers.
  logic [9:0] width_r, height_r;
  logic [2:0] radius_r;
  logic [7:0] nthr_r, dthr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 10'd512;
      height_r <= 10'd512;
      radius_r <= 3'd1;
      nthr_r   <= 8'd10;
      dthr_r   <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        CFG_RADIUS: radius_r <= cfg_wdata[2:0];
        CFG_NTHR:   nthr_r   <= cfg_wdata[7:0];
        CFG_DTHR:   dthr_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Window bounds of an incoming filter item, clipped to the image.
  logic [COORD_W-1:0] xe, ye, rad, wc, hc, left_c, right_c, top_c, bottom_c;
  logic               inside_c;
  always_comb begin
    xe  = COORD_W'(f_x);
    ye  = COORD_W'(f_y);
    rad = (int'(radius_r) > MAX_RADIUS) ? COORD_W'(MAX_RADIUS) : COORD_W'(radius_r);
    wc  = (width_r == '0) ? COORD_W'(1) :
          ((int'(width_r) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : COORD_W'(width_r));
    hc  = (height_r == '0) ? COORD_W'(1) :
          ((int'(height_r) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : COORD_W'(height_r));
    left_c   = (xe > rad) ? xe - rad : '0;
    top_c    = (ye > rad) ? ye - rad : '0;
    right_c  = (xe + rad < wc - 1'b1) ? xe + rad : wc - 1'b1;
    bottom_c = (ye + rad < hc - 1'b1) ? ye + rad : hc - 1'b1;
    inside_c = (int'(f_x) < MAX_WIDTH) && (int'(f_y) < MAX_HEIGHT);
  end

  logic [COORD_W-1:0] x_r, y_r, left_r, right_r, top_r, bottom_r, i_r, j_r;
  logic               empty_r, outside_r;

  // Item capture and window walk, column by column.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r       <= xe;
      y_r       <= ye;
      left_r    <= left_c;
      right_r   <= right_c;
      top_r     <= top_c;
      bottom_r  <= bottom_c;
      i_r       <= left_c;
      j_r       <= top_c;
      empty_r   <= (left_c > right_c) || (top_c > bottom_c);
      outside_r <= !inside_c;
    end else if (cmd.scan_issue) begin
      if (j_r == bottom_r) begin
        j_r <= top_r;
        i_r <= i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
  end

  // Frame memory: colour, normal and depth of one pixel per word.
  logic [PIX_W-1:0] pix_mem [PIXELS];
  logic [PIX_W-1:0] pix_rd_r;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             pix_we;

  assign pix_we  = cmd.accept && (in_action == ACT_LOAD) && inside_c;
  assign wr_addr = AW'(int'(f_y) * MAX_WIDTH + int'(f_x));
  assign rd_addr = cmd.rd_centre ? AW'(int'(y_r) * MAX_WIDTH + int'(x_r))
                                 : AW'(int'(j_r) * MAX_WIDTH + int'(i_r));

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[wr_addr] <= f_pix;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_centre || cmd.scan_issue) pix_rd_r <= pix_mem[rd_addr];
  end

  // Spatial weight table, addressed by squared distance.
  logic [WVAL_W-1:0] wt_mem [WENT];
  logic [WVAL_W-1:0] wt_rd_r;
  logic [RW-1:0]     dx, dy;
  logic [WIW-1:0]    d2;

  assign dx = RW'((i_r > x_r) ? i_r - x_r : x_r - i_r);
  assign dy = RW'((j_r > y_r) ? j_r - y_r : y_r - j_r);
  assign d2 = WIW'(dx) * WIW'(dx) + WIW'(dy) * WIW'(dy);

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_action == ACT_WEIGHT) && (int'(f_widx) < WENT))
      wt_mem[WIW'(f_widx)] <= f_wval;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) wt_rd_r <= wt_mem[d2];
  end

  // Guide data of the centre pixel.
  logic [PIX_W-1:0] centre_r;
  always_ff @(posedge clk) begin
    if (cmd.latch_centre) centre_r <= pix_rd_r;
  end

  // Stage two: neighbour test and weight-by-colour products.
  logic              s1_valid_r, s2_valid_r, qual;
  logic [P_W-1:0]    prod_r [3];
  logic [WVAL_W-1:0] s2_wt_r;

  always_comb begin
    logic [CH_W-1:0] a, b, diff;
    qual = 1'b1;
    for (int k = 0; k < 4; k++) begin
      a    = pix_rd_r[24 + 8*k +: 8];
      b    = centre_r[24 + 8*k +: 8];
      diff = (a > b) ? a - b : b - a;
      if (k < 3) begin
        if (diff >= nthr_r) qual = 1'b0;
      end else begin
        if (diff >= dthr_r) qual = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.scan_issue;
      s2_valid_r <= s1_valid_r && qual;
    end
  end

  always_ff @(posedge clk) begin
    s2_wt_r <= wt_rd_r;
    for (int k = 0; k < 3; k++) prod_r[k] <= wt_rd_r * pix_rd_r[8*k +: 8];
  end

  // Stage three: weight and colour sums.
  logic [SW_W-1:0] sw_r;
  logic [S_W-1:0]  sum_r [3];
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sw_r <= '0;
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
    end else if (s2_valid_r) begin
      sw_r <= sw_r + SW_W'(s2_wt_r);
      for (int k = 0; k < 3; k++) sum_r[k] <= sum_r[k] + S_W'(prod_r[k]);
    end
  end

  // Restoring dividers, one quotient bit per channel each step, most significant first.
  logic [S_W-1:0]  rem_r [3];
  logic [S_W-1:0]  rem_nxt [3];
  logic [CH_W-1:0] quo_r [3];
  logic [2:0]      bit_r;
  logic [2:0]      qbit;
  logic [S_W-1:0]  dsh;

  always_comb begin
    dsh = S_W'(sw_r) << bit_r;
    for (int k = 0; k < 3; k++) begin
      qbit[k]    = rem_r[k] >= dsh;
      rem_nxt[k] = qbit[k] ? rem_r[k] - dsh : rem_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      bit_r <= 3'd7;
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= sum_r[k];
        quo_r[k] <= '0;
      end
    end else if (cmd.div_step) begin
      bit_r <= bit_r - 1'b1;
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= {quo_r[k][CH_W-2:0], qbit[k]};
      end
    end
  end

  // Output register.
  logic                  out_valid_r, zero_res;
  logic [OUT_DATA_W-1:0] out_data_r;
  assign zero_res = outside_r || (sw_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out)
      out_data_r <= zero_res ? '0 : {quo_r[2], quo_r[1], quo_r[0]};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.empty     = empty_r;
  assign sts.outside   = outside_r;
  assign sts.scan_last = (i_r == right_r) && (j_r == bottom_r);
  assign sts.pipe_busy = s1_valid_r || s2_valid_r;
  assign sts.out_busy  = out_valid_r && !out_tready;

endmodule
`default_nettype wire

@@ design/gbd_ctrl.sv @@
// Controller of the guided bilateral denoiser: sequences centre read, window
// scan, pipeline drain, division and result hand-off. Depends on gbd_pkg.
`default_nettype none
module gbd_ctrl import gbd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic [ACTION_W-1:0] in_action,
  output logic                     in_tready,
  output gbd_cmd_t                 cmd,
  input  wire gbd_sts_t            sts
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CENTRE, ST_CLATCH, ST_SCAN, ST_DRAIN, ST_DIV, ST_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.accept = in_tvalid && in_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && (in_action == ACT_FILTER)) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CENTRE;
        end
      end
      ST_CENTRE: begin
        if (sts.outside) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.rd_centre = 1'b1;
          state_nxt     = ST_CLATCH;
        end
      end
      ST_CLATCH: begin
        cmd.latch_centre = 1'b1;
        if (sts.empty) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == 3'd7) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/guided_bilateral_denoise.sv @@
// Guided bilateral denoiser, top level: joins the controller and the datapath.
// Depends on gbd_pkg, gbd_ctrl and gbd_datapath.
//
// Load-pixel and load-weight items take one cycle each and are accepted even
// while a result waits on the output. A filter item reads its centre pixel and
// then one window pixel per cycle from the frame memory; the clipped window
// holds up to (2*MAX_RADIUS+1)^2 pixels, 225 by default. Besides the scan, an
// item passes through the centre read and latch, a pipeline drain and the
// eight-step divider. A window that is empty after clipping skips scan and
// drain, and an item outside the frame stores goes straight to the output
// register; both give a zero result. No new item is taken until the filter
// result has been moved into the output register, so output stalls hold off
// the next item. Frame stores and the weight table have no reset; reading an
// entry never written gives an undefined result.
`default_nettype none
module guided_bilateral_denoise import gbd_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // x[8:0], y[17:9], red[25:18], green[33:26], blue[41:34], normal_x[49:42],
  // normal_y[57:50], normal_z[65:58], depth[73:66], weight_index[80:74],
  // weight_value[97:81], zero fill[103:98]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  wire logic [ACTION_W-1:0]   in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  gbd_cmd_t cmd;
  gbd_sts_t sts;

  gbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gbd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_action  (in_tuser),
    .in_data    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

@@ design/gbd_checker.sv @@
// Port-level checker for the guided bilateral denoiser and its bind to the top level.
// Depends on gbd_pkg.
`default_nettype none
module gbd_checker import gbd_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [ACTION_W-1:0]   in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // A filter transfer holds off further input for at least the next cycle.
  a_filter_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser == ACT_FILTER) |=> !in_tready)
    else $error("input ready right after a filter transfer");

  // Load, weight and unused items never create a result.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser != ACT_FILTER) && !out_tvalid |=> !out_tvalid)
    else $error("result appeared after a load transfer");

  // Reset empties the output.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled result holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind guided_bilateral_denoise gbd_checker u_gbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for guided_bilateral_denoise: a directed table, then
// random phases under several register settings, checked by a built-in filter model or typed values.
// Depends on gbd_pkg and the guided_bilateral_denoise RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import gbd_pkg::*;

  localparam int FRAME_W = 512;
  localparam int FRAME_H = 512;
  localparam int RAD_MAX = 7;
  localparam int WT_ENTRIES = 2 * RAD_MAX * RAD_MAX + 1;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // One input item, with an optional hand-written expected pixel.
  typedef struct {
    logic [ACTION_W-1:0] act;
    int unsigned px;
    int unsigned py;
    logic [23:0] rgb;      // red in the low byte
    logic [23:0] nrm;      // normal_x in the low byte
    logic [7:0]  dep;
    logic [6:0]  widx;
    logic [16:0] wval;
    bit          typed;
    logic [23:0] typed_rgb;
  } item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [ACTION_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Shadow copy of the frame stores, the weight table and the registers.
  logic [23:0] colour_mem [FRAME_W*FRAME_H];
  logic [23:0] normal_mem [FRAME_W*FRAME_H];
  logic [7:0]  depth_mem  [FRAME_W*FRAME_H];
  bit          loaded     [FRAME_W*FRAME_H];
  logic [16:0] spatial_wt [WT_ENTRIES];
  logic [9:0]  reg_width = 10'd512;
  logic [9:0]  reg_height = 10'd512;
  logic [2:0]  reg_radius = 3'd1;
  logic [7:0]  reg_nthr = 8'd10;
  logic [7:0]  reg_dthr = 8'd2;

  logic [23:0] pending_pixels [$];
  int errors = 0;
  int filters_sent = 0;
  int items_sent = 0;
  int idle_pct = 36;

  guided_bilateral_denoise dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned absd(int unsigned a, int unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  // Weighted mean over the clipped window, keeping neighbours close in normal and depth.
  function automatic logic [23:0] filtered_pixel(int unsigned px, int unsigned py);
    int unsigned w, h, r, lo_x, lo_y, hi_x, hi_y, c, n, d2;
    longint unsigned wsum, csum[3], wt;
    logic [23:0] res;
    bit keep;
    w = reg_width == 0 ? 1 : (reg_width > FRAME_W ? FRAME_W : reg_width);
    h = reg_height == 0 ? 1 : (reg_height > FRAME_H ? FRAME_H : reg_height);
    r = reg_radius > RAD_MAX ? RAD_MAX : reg_radius;
    lo_x = px > r ? px - r : 0;
    lo_y = py > r ? py - r : 0;
    hi_x = (px + r < w - 1) ? px + r : w - 1;
    hi_y = (py + r < h - 1) ? py + r : h - 1;
    c = py * FRAME_W + px;
    wsum = 0;
    csum = '{0, 0, 0};
    for (int unsigned i = lo_x; i <= hi_x; i++) begin
      for (int unsigned j = lo_y; j <= hi_y; j++) begin
        n = j * FRAME_W + i;
        keep = absd(depth_mem[n], depth_mem[c]) < reg_dthr;
        for (int k = 0; k < 3; k++)
          if (absd(normal_mem[n][8*k +: 8], normal_mem[c][8*k +: 8]) >= reg_nthr) keep = 0;
        d2 = absd(i, px) * absd(i, px) + absd(j, py) * absd(j, py);
        if (keep && d2 < WT_ENTRIES) begin
          wt = spatial_wt[d2];
          wsum += wt;
          for (int k = 0; k < 3; k++) csum[k] += wt * colour_mem[n][8*k +: 8];
        end
      end
    end
    for (int k = 0; k < 3; k++) res[8*k +: 8] = wsum == 0 ? 8'd0 : 8'(csum[k] / wsum);
    return res;
  endfunction

  // Random idle, then one transfer; the model state follows the accepted item.
  task automatic send(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.act;
    in_tdata <= {6'd0, it.wval, it.widx, it.dep, it.nrm, it.rgb, 9'(it.py), 9'(it.px)};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    case (it.act)
      ACT_LOAD: begin
        colour_mem[it.py * FRAME_W + it.px] = it.rgb;
        normal_mem[it.py * FRAME_W + it.px] = it.nrm;
        depth_mem[it.py * FRAME_W + it.px] = it.dep;
        loaded[it.py * FRAME_W + it.px] = 1;
      end
      ACT_WEIGHT: if (it.widx < WT_ENTRIES) spatial_wt[it.widx] = it.wval;
      ACT_FILTER: begin
        filters_sent++;
        pending_pixels.push_back(it.typed ? it.typed_rgb : filtered_pixel(it.px, it.py));
      end
      default: ;
    endcase
  endtask

  function automatic item_t mk(logic [ACTION_W-1:0] act, int unsigned px, int unsigned py,
                               logic [23:0] rgb, logic [23:0] nrm, logic [7:0] dep);
    item_t it;
    it.act = act; it.px = px; it.py = py; it.rgb = rgb; it.nrm = nrm; it.dep = dep;
    it.widx = 7'($urandom); it.wval = 17'($urandom);
    it.typed = 0; it.typed_rgb = '0;
    return it;
  endfunction

  function automatic item_t mk_weight(logic [6:0] idx, logic [16:0] val);
    item_t it;
    it = mk(ACT_WEIGHT, $urandom_range(511), $urandom_range(511), 24'($urandom),
            24'($urandom), 8'($urandom));
    it.widx = idx; it.wval = val;
    return it;
  endfunction

  // Guide data mostly clustered so that some neighbours qualify and some do not.
  function automatic item_t rand_load(int unsigned px, int unsigned py);
    logic [23:0] nrm;
    logic [7:0] dep;
    if ($urandom_range(9) == 0) begin
      nrm = 24'($urandom); dep = 8'($urandom);
    end else begin
      for (int k = 0; k < 3; k++) nrm[8*k +: 8] = 8'(120 + $urandom_range(16));
      dep = 8'(100 + $urandom_range(5));
    end
    return mk(ACT_LOAD, px, py, 24'($urandom), nrm, dep);
  endfunction

  // Loads the centre, if never written, and every never-written pixel of the clipped window at (px, py).
  task automatic fill_window(int unsigned px, int unsigned py);
    int unsigned r, w, h, hi_x, hi_y;
    r = reg_radius;
    w = reg_width == 0 ? 1 : (reg_width > FRAME_W ? FRAME_W : reg_width);
    h = reg_height == 0 ? 1 : (reg_height > FRAME_H ? FRAME_H : reg_height);
    hi_x = (px + r < w - 1) ? px + r : w - 1;
    hi_y = (py + r < h - 1) ? py + r : h - 1;
    if (!loaded[py * FRAME_W + px]) send(rand_load(px, py));
    for (int unsigned i = (px > r ? px - r : 0); i <= hi_x; i++)
      for (int unsigned j = (py > r ? py - r : 0); j <= hi_y; j++)
        if (!loaded[j * FRAME_W + i]) send(rand_load(i, j));
  endtask

  // Waits until every filter result has arrived and the block has settled.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_regs(logic [9:0] w, logic [9:0] h, logic [2:0] r,
                          logic [7:0] nt, logic [7:0] dt);
    logic [CFG_DATA_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0] idxs [5];
    vals = '{w, h, 10'(r), 10'(nt), 10'(dt)};
    idxs = '{CFG_WIDTH, CFG_HEIGHT, CFG_RADIUS, CFG_NTHR, CFG_DTHR};
    for (int k = 0; k < 5; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idxs[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    reg_width = w; reg_height = h; reg_radius = r; reg_nthr = nt; reg_dthr = dt;
  endtask

  // Output side: random backpressure and an in-order comparison per channel.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("result with no filter item outstanding: %h", out_tdata);
        errors++;
      end else begin
        logic [23:0] want;
        want = pending_pixels.pop_front();
        if (out_tdata[7:0] !== want[7:0]) begin
          $error("out_red expected %0d got %0d", want[7:0], out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== want[15:8]) begin
          $error("out_green expected %0d got %0d", want[15:8], out_tdata[15:8]);
          errors++;
        end
        if (out_tdata[23:16] !== want[23:16]) begin
          $error("out_blue expected %0d got %0d", want[23:16], out_tdata[23:16]);
          errors++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d results outstanding", pending_pixels.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    item_t directed [$];
    item_t it;
    int unsigned px, py, pick, n_rand;
    logic [9:0] ph_w [6];
    logic [9:0] ph_h [6];
    logic [2:0] ph_r [6];
    logic [7:0] ph_n [6];
    logic [7:0] ph_d [6];

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole weight table; the centre weight is exactly one.
    for (int k = 0; k < WT_ENTRIES; k++)
      send(mk_weight(7'(k), k == 0 ? 17'd65536 : 17'($urandom_range(65536))));

    // Directed table, under the reset register values.
    directed.push_back(mk(ACT_LOAD, 0, 0, 24'hFF00FF, 24'h000000, 8'd0));
    directed.push_back(mk(ACT_LOAD, 1, 0, 24'h123456, 24'hFFFFFF, 8'd255));
    directed.push_back(mk(ACT_LOAD, 0, 1, 24'h654321, 24'hFFFFFF, 8'd255));
    directed.push_back(mk(ACT_LOAD, 1, 1, 24'hABCDEF, 24'hFFFFFF, 8'd255));
    // Lone corner pixel: only the centre qualifies, so its colour comes back.
    it = mk(ACT_FILTER, 0, 0, '0, '0, '0);
    it.typed = 1; it.typed_rgb = 24'hFF00FF;
    directed.push_back(it);
    directed.push_back(mk(ACT_LOAD, 511, 511, 24'h00FF00, 24'hFFFFFF, 8'd255));
    directed.push_back(mk(ACT_LOAD, 510, 511, 24'h111111, 24'h000000, 8'd0));
    directed.push_back(mk(ACT_LOAD, 511, 510, 24'h222222, 24'h000000, 8'd0));
    directed.push_back(mk(ACT_LOAD, 510, 510, 24'h333333, 24'h000000, 8'd0));
    it = mk(ACT_FILTER, 511, 511, '0, '0, '0);
    it.typed = 1; it.typed_rgb = 24'h00FF00;
    directed.push_back(it);
    // Neighbours that qualify against (1,0).
    directed.push_back(mk(ACT_LOAD, 2, 0, 24'h80FF01, 24'hFEFFFF, 8'd254));
    directed.push_back(mk(ACT_LOAD, 2, 1, 24'h7F00FE, 24'hFFFEFA, 8'd255));
    // Indexes past the table are dropped; a weight above one is kept.
    directed.push_back(mk_weight(7'd99, 17'd0));
    directed.push_back(mk_weight(7'd127, 17'h1FFFF));
    directed.push_back(mk_weight(7'd1, 17'h1FFFF));
    directed.push_back(mk(ACT_UNUSED, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 8'hFF));
    directed.push_back(mk(ACT_FILTER, 1, 0, '0, '0, '0));
    directed.push_back(mk_weight(7'd98, 17'd65536));
    directed.push_back(mk(ACT_FILTER, 1, 0, '0, '0, '0));
    foreach (directed[k]) send(directed[k]);
    drain();

    // Register settings for the random phases, extremes included.
    ph_w = '{10'd512, 10'd10, 10'd0, 10'd1023, 10'd12, 10'd5};
    ph_h = '{10'd512, 10'd10, 10'd0, 10'd1023, 10'd9, 10'd20};
    ph_r = '{3'd1, 3'd7, 3'd3, 3'd2, 3'd7, 3'd0};
    ph_n = '{8'd10, 8'd255, 8'd20, 8'd0, 8'd40, 8'd15};
    ph_d = '{8'd2, 8'd255, 8'd5, 8'd0, 8'd8, 8'd3};
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(ph_w[ph], ph_h[ph], ph_r[ph], ph_n[ph], ph_d[ph]);
      idle_pct = (ph == 2) ? 0 : 36;
      n_rand = 0;
      while (n_rand < 25) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          // Filter, with its window made readable first.
          case ($urandom_range(19))
            0: begin px = 500 + $urandom_range(11); py = 500 + $urandom_range(11); end
            1: begin px = $urandom_range(511); py = $urandom_range(511); end
            default: begin px = $urandom_range(9); py = $urandom_range(9); end
          endcase
          fill_window(px, py);
          send(mk(ACT_FILTER, px, py, 24'($urandom), 24'($urandom), 8'($urandom)));
        end else if (pick < 80) begin
          send(rand_load($urandom_range(9), $urandom_range(9)));
        end else if (pick < 93) begin
          send(mk_weight(7'($urandom), $urandom_range(3) == 0 ? 17'($urandom)
                                                             : 17'($urandom_range(65536))));
        end else begin
          send(mk(ACT_UNUSED, $urandom_range(511), $urandom_range(511), 24'($urandom),
                  24'($urandom), 8'($urandom)));
        end
        n_rand++;
      end
      drain();
    end

    $display("Covered %0d input transfers including %0d filtered pixels over six settings,",
             items_sent, filters_sent);
    $display("with clipped, empty and zero-threshold windows and random stalls on both sides.");
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ guided_bilateral_denoise.f @@
design/gbd_pkg.sv
design/gbd_datapath.sv
design/gbd_ctrl.sv
design/guided_bilateral_denoise.sv
design/gbd_checker.sv
test/tb_top.sv
